@@ rtl/core/rnum_pkg.sv @@
// Shared types, symbol table and sequencer states for the Roman numeral text unit.
// No dependencies; imported by rnum_front, rnum_back and the top level.
package rnum_pkg;

  localparam int NUM_W    = 12;
  localparam int LETTER_W = 7;
  localparam int SYM_W    = 4;   // index into the thirteen-symbol table
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = 1;
  localparam int Q_CNT_W  = 2;

  localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;
  localparam logic [LETTER_W-1:0] CH_I    = 7'h49;
  localparam logic [LETTER_W-1:0] CH_V    = 7'h56;
  localparam logic [LETTER_W-1:0] CH_X    = 7'h58;
  localparam logic [LETTER_W-1:0] CH_L    = 7'h4C;
  localparam logic [LETTER_W-1:0] CH_C    = 7'h43;
  localparam logic [LETTER_W-1:0] CH_D    = 7'h44;
  localparam logic [LETTER_W-1:0] CH_M    = 7'h4D;

  // Symbol indexes, largest value first.
  localparam logic [SYM_W-1:0] SYM_M  = 4'd0;
  localparam logic [SYM_W-1:0] SYM_CM = 4'd1;
  localparam logic [SYM_W-1:0] SYM_D  = 4'd2;
  localparam logic [SYM_W-1:0] SYM_CD = 4'd3;
  localparam logic [SYM_W-1:0] SYM_C  = 4'd4;
  localparam logic [SYM_W-1:0] SYM_XC = 4'd5;
  localparam logic [SYM_W-1:0] SYM_L  = 4'd6;
  localparam logic [SYM_W-1:0] SYM_XL = 4'd7;
  localparam logic [SYM_W-1:0] SYM_X  = 4'd8;
  localparam logic [SYM_W-1:0] SYM_IX = 4'd9;
  localparam logic [SYM_W-1:0] SYM_V  = 4'd10;
  localparam logic [SYM_W-1:0] SYM_IV = 4'd11;
  localparam logic [SYM_W-1:0] SYM_I  = 4'd12;

  typedef struct packed {
    logic             is_zero;
    logic [NUM_W-1:0] number;
  } rnum_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAD,
    ST_TRAIL
  } rnum_state_t;

  function automatic logic [NUM_W-1:0] sym_weight(input logic [SYM_W-1:0] s);
    logic [NUM_W-1:0] w;
    unique case (s)
      SYM_M:   w = 12'd1000;
      SYM_CM:  w = 12'd900;
      SYM_D:   w = 12'd500;
      SYM_CD:  w = 12'd400;
      SYM_C:   w = 12'd100;
      SYM_XC:  w = 12'd90;
      SYM_L:   w = 12'd50;
      SYM_XL:  w = 12'd40;
      SYM_X:   w = 12'd10;
      SYM_IX:  w = 12'd9;
      SYM_V:   w = 12'd5;
      SYM_IV:  w = 12'd4;
      SYM_I:   w = 12'd1;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  function automatic logic [LETTER_W-1:0] lead_ch(input logic [SYM_W-1:0] s);
    logic [LETTER_W-1:0] c;
    unique case (s)
      SYM_M:   c = CH_M;
      SYM_CM:  c = CH_C;
      SYM_D:   c = CH_D;
      SYM_CD:  c = CH_C;
      SYM_C:   c = CH_C;
      SYM_XC:  c = CH_X;
      SYM_L:   c = CH_L;
      SYM_XL:  c = CH_X;
      SYM_X:   c = CH_X;
      SYM_IX:  c = CH_I;
      SYM_V:   c = CH_V;
      SYM_IV:  c = CH_I;
      SYM_I:   c = CH_I;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  // Second letter of a subtractive pair; CH_NONE for one-letter symbols.
  function automatic logic [LETTER_W-1:0] trail_ch(input logic [SYM_W-1:0] s);
    logic [LETTER_W-1:0] c;
    unique case (s)
      SYM_CM:  c = CH_M;
      SYM_CD:  c = CH_D;
      SYM_XC:  c = CH_C;
      SYM_XL:  c = CH_L;
      SYM_IX:  c = CH_X;
      SYM_IV:  c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/rnum_front.sv @@
// Input side: accepts numbers, flags zero, and holds them in a two-entry queue.
// Depends on rnum_pkg.
module rnum_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [rnum_pkg::NUM_W-1:0] in_number,
  output logic                    q_valid,
  output rnum_pkg::rnum_item_t    q_item,
  input  logic                    q_pop
);
  import rnum_pkg::*;

  rnum_item_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 push;
  logic                 pop;

  assign in_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].number  <= in_number;
      slots[wr_ptr].is_zero <= (in_number == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/rnum_back.sv @@
// Output side: greedy letter sequencer with a registered output stage.
// Depends on rnum_pkg; fed by rnum_front.
module rnum_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  rnum_pkg::rnum_item_t       q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rnum_pkg::LETTER_W-1:0] out_letter,
  output logic                       out_letter_valid,
  output logic                       out_last
);
  import rnum_pkg::*;

  rnum_state_t          state;
  rnum_state_t          state_next;
  logic [NUM_W-1:0]     rest;
  logic [NUM_W-1:0]     rest_next;
  logic [SYM_W-1:0]     sym;
  logic [SYM_W-1:0]     sym_next;
  logic [SYM_W-1:0]     best;
  logic [NUM_W-1:0]     best_w;
  logic [NUM_W-1:0]     sym_w;
  logic                 best_pair;
  logic                 adv;
  logic                 emit;
  logic [LETTER_W-1:0]  e_letter;
  logic                 e_valid;
  logic                 e_last;

  // Output register is free when empty or being drained this cycle.
  assign adv = !out_valid || out_ready;

  // Largest symbol that still fits: parallel compares, smallest index wins.
  always_comb begin
    best = SYM_I;
    for (int i = SYM_I; i >= 0; i--) begin
      if (rest >= sym_weight(SYM_W'(i))) begin
        best = SYM_W'(i);
      end
    end
  end

  assign best_w    = sym_weight(best);
  assign best_pair = (trail_ch(best) != CH_NONE);
  assign sym_w     = sym_weight(sym);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && adv && !q_item.is_zero) begin
          state_next = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (adv) begin
          if (best_pair) begin
            state_next = ST_TRAIL;
          end else if (rest == best_w) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TRAIL: begin
        if (adv) begin
          state_next = (rest == sym_w) ? ST_IDLE : ST_LEAD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    e_letter  = CH_NONE;
    e_valid   = 1'b0;
    e_last    = 1'b0;
    rest_next = rest;
    sym_next  = sym;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && adv) begin
          q_pop = 1'b1;
          if (q_item.is_zero) begin
            // zero: one empty item that closes the run
            emit   = 1'b1;
            e_last = 1'b1;
          end else begin
            rest_next = q_item.number;
          end
        end
      end
      ST_LEAD: begin
        if (adv) begin
          emit     = 1'b1;
          e_valid  = 1'b1;
          e_letter = lead_ch(best);
          sym_next = best;
          if (!best_pair) begin
            rest_next = rest - best_w;
            e_last    = (rest == best_w);
          end
        end
      end
      ST_TRAIL: begin
        if (adv) begin
          emit      = 1'b1;
          e_valid   = 1'b1;
          e_letter  = trail_ch(sym);
          rest_next = rest - sym_w;
          e_last    = (rest == sym_w);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rest <= rest_next;
    sym  <= sym_next;
    if (emit) begin
      out_letter       <= e_letter;
      out_letter_valid <= e_valid;
      out_last         <= e_last;
    end
  end

endmodule

@@ rtl/core/integer_to_roman_text_unit.sv @@
// Top level of the Roman numeral text unit: input queue plus letter sequencer.
// Depends on rnum_pkg, rnum_front and rnum_back.
//
//  channel  | dir | tdata                               | tlast
//  ---------+-----+-------------------------------------+---------------------
//  s_axis   | in  | [11:0] number, [15:12] unused       | -
//  m_axis   | out | [6:0] letter, [7] letter_valid      | last letter of number
//
// Each number first leaves the queue, then the sequencer gives one letter per cycle
// unless m_axis stalls; 3888 gives the longest numeral, at 15 letters.
// Zero gives a single empty item, registered as it leaves the queue.
// The two-entry queue keeps accepting, until it is full, while the sequencer or m_axis stalls.
// rst is synchronous and clears the queue, the sequencer and the output stage.
module integer_to_roman_text_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] number
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] letter, [7] letter_valid
  output logic        m_axis_tlast    // last
);
  import rnum_pkg::*;

  logic                q_valid;
  logic                q_pop;
  rnum_item_t          q_item;
  logic [LETTER_W-1:0] letter;
  logic                letter_valid;

  rnum_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_number (s_axis_tdata[NUM_W-1:0]),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  rnum_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_letter       (letter),
    .out_letter_valid (letter_valid),
    .out_last         (m_axis_tlast)
  );

  assign m_axis_tdata = {letter_valid, letter};

endmodule

@@ rtl/core/rnum_checker.sv @@
// Port-level checks for integer_to_roman_text_unit, attached by bind.
// Depends only on the top level's ports.
module rnum_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // Stalled item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output item changed while stalled");

  // Empty item only for zero, which is a run of one.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[7]) |-> (m_axis_tlast && m_axis_tdata[6:0] == 7'h00))
    else $error("empty item not alone");

  // Letters are numeral letters only.
  a_letter_set: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[7]) |->
      (m_axis_tdata[6:0] == 7'h49 || m_axis_tdata[6:0] == 7'h56 ||
       m_axis_tdata[6:0] == 7'h58 || m_axis_tdata[6:0] == 7'h4C ||
       m_axis_tdata[6:0] == 7'h43 || m_axis_tdata[6:0] == 7'h44 ||
       m_axis_tdata[6:0] == 7'h4D))
    else $error("letter outside numeral set");

  // An empty item never follows a letter that did not close its run.
  a_no_empty_mid: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tdata[7] && !m_axis_tlast) |=>
      (!m_axis_tvalid || m_axis_tdata[7]))
    else $error("empty item inside a numeral");

endmodule

bind integer_to_roman_text_unit rnum_checker u_rnum_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking bench for integer_to_roman_text_unit: random and directed numbers in,
// Roman numeral letters out, each letter checked against an in-bench greedy converter.
// Depends on rnum_pkg (letter codes) and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rnum_pkg::*;

  localparam int HOLD_LEN = 80;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                letter_valid;
    logic                last;
  } roman_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  logic [NUM_W-1:0] numbers_to_send[$];
  roman_char_t      letters_due[$];
  int unsigned      issue_cnt = 0;
  int unsigned      accept_cnt = 0;
  int unsigned      errors = 0;
  int unsigned      src_idle_pct = 0;
  int unsigned      sink_stall_pct = 0;
  logic             hold_start = 1'b0;
  logic             hold_done = 1'b0;
  int unsigned      hold_cnt = 0;

  integer_to_roman_text_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Symbol table, largest value first; second letter is CH_NONE for single letters.
  function automatic void roman_symbol(input int idx, output int unsigned weight,
                                       output logic [LETTER_W-1:0] first,
                                       output logic [LETTER_W-1:0] second);
    second = CH_NONE;
    case (idx)
      0:  begin weight = 1000; first = CH_M; end
      1:  begin weight = 900;  first = CH_C; second = CH_M; end
      2:  begin weight = 500;  first = CH_D; end
      3:  begin weight = 400;  first = CH_C; second = CH_D; end
      4:  begin weight = 100;  first = CH_C; end
      5:  begin weight = 90;   first = CH_X; second = CH_C; end
      6:  begin weight = 50;   first = CH_L; end
      7:  begin weight = 40;   first = CH_X; second = CH_L; end
      8:  begin weight = 10;   first = CH_X; end
      9:  begin weight = 9;    first = CH_I; second = CH_X; end
      10: begin weight = 5;    first = CH_V; end
      11: begin weight = 4;    first = CH_I; second = CH_V; end
      default: begin weight = 1; first = CH_I; end
    endcase
  endfunction

  // Greedy conversion; appends the letters of one number to letters_due.
  task automatic spell_roman(input logic [NUM_W-1:0] value);
    int unsigned rest;
    int unsigned weight;
    int          count;
    logic [LETTER_W-1:0] first;
    logic [LETTER_W-1:0] second;
    roman_char_t spelled[$];
    rest = value;
    count = 0;
    if (rest == 0) begin
      letters_due.push_back('{letter: CH_NONE, letter_valid: 1'b0, last: 1'b1});
    end else begin
      for (int i = 0; i < 13; i++) begin
        roman_symbol(i, weight, first, second);
        while (rest >= weight && count < 15) begin
          spelled.push_back('{letter: first, letter_valid: 1'b1, last: 1'b0});
          count++;
          if (second != CH_NONE && count < 15) begin
            spelled.push_back('{letter: second, letter_valid: 1'b1, last: 1'b0});
            count++;
          end
          rest -= weight;
        end
      end
      spelled[spelled.size()-1].last = 1'b1;
      foreach (spelled[k]) letters_due.push_back(spelled[k]);
    end
  endtask

  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 5) return '0;
    if (r < 13) return NUM_W'($urandom_range(4095, 4000));
    if (r < 28) return NUM_W'($urandom_range(49, 1));
    return NUM_W'($urandom_range(3999, 1));
  endfunction

  // Driver: next number goes out on the falling edge once the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || accept_cnt == issue_cnt) begin
      if (numbers_to_send.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        s_axis_tdata  <= {4'b0, numbers_to_send.pop_front()};
        s_axis_tvalid <= 1'b1;
        issue_cnt     <= issue_cnt + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (hold_start && !hold_done) begin
      m_axis_tready <= 1'b0;
      if (hold_cnt == HOLD_LEN - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end
  end

  // Monitor: accepted numbers feed the converter, accepted letters are checked.
  always @(posedge clk) begin
    roman_char_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        spell_roman(s_axis_tdata[NUM_W-1:0]);
        accept_cnt <= accept_cnt + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (letters_due.size() == 0) begin
          $display("%0t: unexpected item: letter %h valid %b last %b", $time,
                   m_axis_tdata[6:0], m_axis_tdata[7], m_axis_tlast);
          errors++;
        end else begin
          want = letters_due.pop_front();
          if (m_axis_tdata[6:0] !== want.letter) begin
            $display("%0t: letter mismatch: expected %h, actual %h", $time,
                     want.letter, m_axis_tdata[6:0]);
            errors++;
          end
          if (m_axis_tdata[7] !== want.letter_valid) begin
            $display("%0t: letter_valid mismatch: expected %b, actual %b", $time,
                     want.letter_valid, m_axis_tdata[7]);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time,
                     want.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_quiet();
    while (numbers_to_send.size() != 0 || accept_cnt != issue_cnt ||
           letters_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) numbers_to_send.push_back(pick_number());
  endtask

  initial begin
    logic [NUM_W-1:0] directed[$];
    directed = '{0, 1, 4, 5, 9, 10, 40, 49, 50, 90, 100, 400, 500, 900, 1000,
                 1999, 2048, 1365, 2730, 3444, 3888, 3999, 4000, 4094, 4095};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) numbers_to_send.push_back(directed[i]);
    wait_quiet();

    // Sender keeps offering while the receiver holds off, so the input backs up.
    queue_random(21);
    @(posedge clk);
    hold_start = 1'b1;
    wait (hold_done);
    wait_quiet();

    src_idle_pct = 59;
    queue_random(21);
    wait_quiet();

    src_idle_pct = 0;
    sink_stall_pct = 59;
    queue_random(21);
    wait_quiet();

    src_idle_pct = 34;
    sink_stall_pct = 34;
    queue_random(22);
    wait_quiet();

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
